>>> rtl/afc_pkg.sv
// shared types and constants for the box versus plane culling block
package afc_pkg;

  // default parameter values
  localparam int NUM_PLANES_DEF  = 6;
  localparam int COORD_WIDTH_DEF = 32;

  // fixed field widths
  localparam int FIELD_W     = 32;
  localparam int NORMAL_W    = 16;
  localparam int IDX_W       = 3;
  localparam int TOL_W       = 16;
  localparam int FRAC_SHIFT  = 14;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // operation codes
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  // one plane normal, Q1.14 signed components
  typedef struct packed {
    logic signed [NORMAL_W-1:0] nz;
    logic signed [NORMAL_W-1:0] ny;
    logic signed [NORMAL_W-1:0] nx;
  } normal_t;

  // advance strobes for the per-plane pipeline stages
  typedef struct packed {
    logic adv_prod;
    logic adv_sum;
  } stage_ctl_t;

endpackage

>>> rtl/aabb_frustum_cull.sv
// top level of the box versus bounding-plane culling block
//
// Input channel (in_valid / in_ready): each transfer is either a plane load
// (in_op = load) that writes normal and offset into plane in_plane_index, or
// a box test (in_op = test) with centre and half extents. Loads give no
// result; indexes at or above NUM_PLANES are dropped.
// Result channel (out_valid / out_ready): one out_visible per box test, in
// order. cfg_wr_en / cfg_wr_data write the inside tolerance at once.
// Throughput: one item per cycle while the result channel is not stalled.
// Each test passes the four register stages input, products, sums and
// result; products and sums are held per plane lane, in parallel.
// Loads take effect in order: a test sees every load accepted before it.
// Reset clears all planes to zero (always pass) and sets the tolerance to 1.
// When the receiver stalls, held results stay put and stages behind them
// keep filling; in_ready falls only once every stage holds an item.
module aabb_frustum_cull #(
  parameter int NUM_PLANES  = afc_pkg::NUM_PLANES_DEF,
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [afc_pkg::IDX_W-1:0]              in_plane_index,
  input  logic signed [afc_pkg::NORMAL_W-1:0]    in_normal_x,
  input  logic signed [afc_pkg::NORMAL_W-1:0]    in_normal_y,
  input  logic signed [afc_pkg::NORMAL_W-1:0]    in_normal_z,
  input  logic signed [afc_pkg::FIELD_W-1:0]     in_plane_offset,
  input  logic signed [afc_pkg::FIELD_W-1:0]     in_center_x,
  input  logic signed [afc_pkg::FIELD_W-1:0]     in_center_y,
  input  logic signed [afc_pkg::FIELD_W-1:0]     in_center_z,
  input  logic signed [afc_pkg::FIELD_W-1:0]     in_extent_x,
  input  logic signed [afc_pkg::FIELD_W-1:0]     in_extent_y,
  input  logic signed [afc_pkg::FIELD_W-1:0]     in_extent_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_visible,
  input  logic                                   cfg_wr_en,
  input  logic [afc_pkg::TOL_W-1:0]              cfg_wr_data
);

  // value width: above 32 bits the low 32 bits read as non-negative
  localparam int VW   = (COORD_WIDTH > afc_pkg::FIELD_W) ? afc_pkg::FIELD_W + 1 : COORD_WIDTH;
  localparam int NRAW = 7;

  // stage 1 input register
  logic                         v1_r;
  afc_pkg::op_t                 op_r;
  logic [afc_pkg::IDX_W-1:0]    idx_r;
  afc_pkg::normal_t             normal_r;
  logic [afc_pkg::FIELD_W-1:0]  raw_r [NRAW];
  logic signed [VW-1:0]         val   [NRAW];

  logic                         v2_r, v3_r;
  logic                         out_valid_r, out_visible_r;
  logic [afc_pkg::TOL_W-1:0]    tol_r;
  logic                         en1, en2, en3, en4;
  afc_pkg::stage_ctl_t          ctl;
  logic                         load_wr;

  logic [VW-1:0]                ex, ey, ez;
  afc_pkg::normal_t             normals [NUM_PLANES];
  logic signed [VW-1:0]         offsets [NUM_PLANES];
  logic [NUM_PLANES-1:0]        pass;

  // stage advance: a stage moves when it is empty or the next one moves
  assign en4 = !out_valid_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  assign ctl.adv_prod = en2;
  assign ctl.adv_sum  = en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r && (op_r == afc_pkg::OP_TEST);
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (in_valid && en1) begin
      op_r        <= afc_pkg::op_t'(in_op);
      idx_r       <= in_plane_index;
      normal_r.nx <= in_normal_x;
      normal_r.ny <= in_normal_y;
      normal_r.nz <= in_normal_z;
      raw_r[0]    <= in_plane_offset;
      raw_r[1]    <= in_center_x;
      raw_r[2]    <= in_center_y;
      raw_r[3]    <= in_center_z;
      raw_r[4]    <= in_extent_x;
      raw_r[5]    <= in_extent_y;
      raw_r[6]    <= in_extent_z;
    end
  end

  // coordinate width reduction
  for (genvar k = 0; k < NRAW; k++) begin : g_val
    if (COORD_WIDTH > afc_pkg::FIELD_W) begin : g_wide
      assign val[k] = $signed({1'b0, raw_r[k]});
    end else begin : g_narrow
      assign val[k] = $signed(raw_r[k][VW-1:0]);
    end
  end

  // absolute half extents, most negative value maps exactly
  assign ex = val[4][VW-1] ? (~val[4] + 1'b1) : val[4];
  assign ey = val[5][VW-1] ? (~val[5] + 1'b1) : val[5];
  assign ez = val[6][VW-1] ? (~val[6] + 1'b1) : val[6];

  // a load writes its plane as it leaves the input stage
  assign load_wr = v1_r && (op_r == afc_pkg::OP_LOAD) && en2;

  afc_plane_store #(
    .NUM_PLANES (NUM_PLANES),
    .VW         (VW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (load_wr),
    .wr_index  (idx_r),
    .wr_normal (normal_r),
    .wr_offset (val[0]),
    .normals   (normals),
    .offsets   (offsets)
  );

  // one test lane per plane
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
    afc_plane_test #(
      .VW (VW)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .normal (normals[i]),
      .offset (offsets[i]),
      .cx     (val[1]),
      .cy     (val[2]),
      .cz     (val[3]),
      .ex     (ex),
      .ey     (ey),
      .ez     (ez),
      .tol    (tol_r),
      .pass   (pass[i])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (en4) begin
      out_visible_r <= &pass;
    end
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= afc_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

>>> rtl/afc_plane_store.sv
// plane register file: normals and offsets, cleared at reset, one write port
module afc_plane_store #(
  parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF,
  parameter int VW         = afc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [afc_pkg::IDX_W-1:0]       wr_index,
  input  afc_pkg::normal_t                wr_normal,
  input  logic signed [VW-1:0]            wr_offset,
  output afc_pkg::normal_t                normals [NUM_PLANES],
  output logic signed [VW-1:0]            offsets [NUM_PLANES]
);

  afc_pkg::normal_t     normal_r [NUM_PLANES];
  logic signed [VW-1:0] offset_r [NUM_PLANES];

  // one entry per plane, index decoded against its own slot
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        normal_r[i] <= '0;
        offset_r[i] <= '0;
      end else if (wr_en && (wr_index == afc_pkg::IDX_W'(i))) begin
        normal_r[i] <= wr_normal;
        offset_r[i] <= wr_offset;
      end
    end
    assign normals[i] = normal_r[i];
    assign offsets[i] = offset_r[i];
  end

endmodule

>>> rtl/afc_plane_test.sv
// one plane test lane: products, then distance and radius sums, then compare
module afc_plane_test #(
  parameter int VW = afc_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  afc_pkg::stage_ctl_t         ctl,
  input  afc_pkg::normal_t            normal,
  input  logic signed [VW-1:0]        offset,
  input  logic signed [VW-1:0]        cx,
  input  logic signed [VW-1:0]        cy,
  input  logic signed [VW-1:0]        cz,
  input  logic [VW-1:0]               ex,
  input  logic [VW-1:0]               ey,
  input  logic [VW-1:0]               ez,
  input  logic [afc_pkg::TOL_W-1:0]   tol,
  output logic                        pass
);

  localparam int PW = VW + afc_pkg::NORMAL_W;
  localparam int SW = VW + afc_pkg::NORMAL_W + 4;

  logic [afc_pkg::NORMAL_W-1:0] anx, any, anz;
  logic signed [PW-1:0] cnx_r, cny_r, cnz_r;
  logic [PW-1:0]        enx_r, eny_r, enz_r;
  logic signed [VW-1:0] d_r;
  logic signed [SW-1:0] s_r, s_nxt;
  logic signed [SW-1:0] r_r, r_nxt;
  logic signed [SW-1:0] diff, tol_q;

  // absolute normal, the most negative value maps to 32768 exactly
  assign anx = normal.nx[afc_pkg::NORMAL_W-1] ? (~normal.nx + 1'b1) : normal.nx;
  assign any = normal.ny[afc_pkg::NORMAL_W-1] ? (~normal.ny + 1'b1) : normal.ny;
  assign anz = normal.nz[afc_pkg::NORMAL_W-1] ? (~normal.nz + 1'b1) : normal.nz;

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.adv_prod) begin
      cnx_r <= PW'(cx) * PW'(normal.nx);
      cny_r <= PW'(cy) * PW'(normal.ny);
      cnz_r <= PW'(cz) * PW'(normal.nz);
      enx_r <= PW'(ex) * PW'(anx);
      eny_r <= PW'(ey) * PW'(any);
      enz_r <= PW'(ez) * PW'(anz);
      d_r   <= offset;
    end
  end

  // center distance and projected radius
  always_comb begin
    s_nxt = SW'(cnx_r) + SW'(cny_r) + SW'(cnz_r) + (SW'(d_r) <<< afc_pkg::FRAC_SHIFT);
    r_nxt = $signed(SW'(enx_r) + SW'(eny_r) + SW'(enz_r));
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_sum) begin
      s_r <= s_nxt;
      r_r <= r_nxt;
    end
  end

  // inside test against the tolerance moved to Q.30
  assign tol_q = $signed(SW'(tol) <<< afc_pkg::FRAC_SHIFT);
  assign diff  = s_r - r_r;
  assign pass  = !(diff > tol_q);

endmodule

>>> tb/sv/afc_tb_pkg.sv
`timescale 1ns / 100ps
// item type and visibility scoreboard for the culling block testbench
package afc_tb_pkg;
  import afc_pkg::*;

  localparam int     PLANE_CNT = NUM_PLANES_DEF;
  // offsets are Q16.16, tolerance is Q0.16, normal times coordinate products are Q.30
  localparam longint Q30_SCALE = longint'(1) << FRAC_SHIFT;

  // one input transfer, every field present whatever the op
  typedef struct {
    op_t                        op;
    logic [IDX_W-1:0]           plane_index;
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic signed [FIELD_W-1:0]  plane_offset;
    logic signed [FIELD_W-1:0]  center_x;
    logic signed [FIELD_W-1:0]  center_y;
    logic signed [FIELD_W-1:0]  center_z;
    logic signed [FIELD_W-1:0]  extent_x;
    logic signed [FIELD_W-1:0]  extent_y;
    logic signed [FIELD_W-1:0]  extent_z;
  } cull_item_t;

  class cull_scoreboard;
    normal_t                   plane_normal [PLANE_CNT];
    logic signed [FIELD_W-1:0] plane_dist [PLANE_CNT];
    logic [TOL_W-1:0]          tolerance;
    bit                        visible_q [$];
    int                        errors;

    function new();
      foreach (plane_normal[i]) begin
        plane_normal[i] = '0;
        plane_dist[i]   = '0;
      end
      tolerance = TOL_RESET;
      errors    = 0;
    endfunction

    function void set_tolerance(logic [TOL_W-1:0] value);
      tolerance = value;
    endfunction

    static function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // box passes when center distance minus projected radius stays within slack
    function bit box_visible(cull_item_t it);
      longint cx, cy, cz, ex, ey, ez;
      longint nx, ny, nz, off, center_dist, radius, slack;
      bit     vis;
      cx    = it.center_x;
      cy    = it.center_y;
      cz    = it.center_z;
      ex    = magnitude(it.extent_x);
      ey    = magnitude(it.extent_y);
      ez    = magnitude(it.extent_z);
      slack = longint'(tolerance) * Q30_SCALE;
      vis   = 1'b1;
      for (int i = 0; i < PLANE_CNT; i++) begin
        nx          = $signed(plane_normal[i].nx);
        ny          = $signed(plane_normal[i].ny);
        nz          = $signed(plane_normal[i].nz);
        off         = plane_dist[i];
        center_dist = cx * nx + cy * ny + cz * nz + off * Q30_SCALE;
        radius      = ex * magnitude(nx) + ey * magnitude(ny) + ez * magnitude(nz);
        if (center_dist - radius > slack) vis = 1'b0;
      end
      return vis;
    endfunction

    // accepted input transfer: loads update the planes, tests queue a verdict
    function void note_input(cull_item_t it);
      if (it.op == OP_LOAD) begin
        if (it.plane_index < PLANE_CNT) begin
          plane_normal[it.plane_index].nx = it.normal_x;
          plane_normal[it.plane_index].ny = it.normal_y;
          plane_normal[it.plane_index].nz = it.normal_z;
          plane_dist[it.plane_index]      = it.plane_offset;
        end
      end else begin
        visible_q.push_back(box_visible(it));
      end
    endfunction

    // accepted result transfer against the oldest queued verdict
    function void check_result(logic visible);
      bit want;
      if (visible_q.size() == 0) begin
        $error("visible: no result expected, actual %0b", visible);
        errors++;
      end else begin
        want = visible_q.pop_front();
        if (visible !== want) begin
          $error("visible mismatch: expected %0b, actual %0b", want, visible);
          errors++;
        end
      end
    endfunction

    function int pending();
      return visible_q.size();
    endfunction
  endclass

endpackage

>>> tb/sv/tb_aabb_frustum_cull.sv
`timescale 1ns / 100ps
// top level testbench for the box versus bounding-plane culling block
module tb_aabb_frustum_cull;
  import afc_pkg::*;
  import afc_tb_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 290;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_op = 1'b0;
  logic [IDX_W-1:0]           in_plane_index = '0;
  logic signed [NORMAL_W-1:0] in_normal_x = '0;
  logic signed [NORMAL_W-1:0] in_normal_y = '0;
  logic signed [NORMAL_W-1:0] in_normal_z = '0;
  logic signed [FIELD_W-1:0]  in_plane_offset = '0;
  logic signed [FIELD_W-1:0]  in_center_x = '0;
  logic signed [FIELD_W-1:0]  in_center_y = '0;
  logic signed [FIELD_W-1:0]  in_center_z = '0;
  logic signed [FIELD_W-1:0]  in_extent_x = '0;
  logic signed [FIELD_W-1:0]  in_extent_y = '0;
  logic signed [FIELD_W-1:0]  in_extent_z = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_visible;
  logic                       cfg_wr_en = 1'b0;
  logic [TOL_W-1:0]           cfg_wr_data = '0;

  int             idle_pct = 0;
  int             stall_pct = 0;
  int             cycle_count = 0;
  cull_scoreboard sb = new();

  aabb_frustum_cull dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_plane_index (in_plane_index),
    .in_normal_x    (in_normal_x),
    .in_normal_y    (in_normal_y),
    .in_normal_z    (in_normal_z),
    .in_plane_offset(in_plane_offset),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_center_z    (in_center_z),
    .in_extent_x    (in_extent_x),
    .in_extent_y    (in_extent_y),
    .in_extent_z    (in_extent_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_visible    (out_visible),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_aabb_frustum_cull: done, errors");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  // result side: check each transfer, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_visible);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // every field random, so fields unused by the op carry noise
  function automatic cull_item_t noise_item();
    cull_item_t it;
    it.op           = op_t'($urandom_range(1));
    it.plane_index  = IDX_W'($urandom_range(7));
    it.normal_x     = NORMAL_W'($urandom);
    it.normal_y     = NORMAL_W'($urandom);
    it.normal_z     = NORMAL_W'($urandom);
    it.plane_offset = $urandom;
    it.center_x     = $urandom;
    it.center_y     = $urandom;
    it.center_z     = $urandom;
    it.extent_x     = $urandom;
    it.extent_y     = $urandom;
    it.extent_z     = $urandom;
    return it;
  endfunction

  function automatic cull_item_t load_item(int idx, int nx, int ny, int nz, int off);
    cull_item_t it;
    it              = noise_item();
    it.op           = OP_LOAD;
    it.plane_index  = IDX_W'(idx);
    it.normal_x     = NORMAL_W'(nx);
    it.normal_y     = NORMAL_W'(ny);
    it.normal_z     = NORMAL_W'(nz);
    it.plane_offset = off;
    return it;
  endfunction

  function automatic cull_item_t test_item(int cx, int cy, int cz, int ex, int ey, int ez);
    cull_item_t it;
    it          = noise_item();
    it.op       = OP_TEST;
    it.center_x = cx;
    it.center_y = cy;
    it.center_z = cz;
    it.extent_x = ex;
    it.extent_y = ey;
    it.extent_z = ez;
    return it;
  endfunction

  // signed value in +-2^span, keeps tests near the plane boundaries
  function automatic logic signed [FIELD_W-1:0] near_value(int span);
    return FIELD_W'($urandom_range(2 << span)) - (FIELD_W'(1) << span);
  endfunction

  // mostly small planes and boxes so verdicts hinge on the tolerance
  function automatic cull_item_t random_item();
    cull_item_t                 it;
    int                         pick;
    logic signed [NORMAL_W-1:0] unit;
    it   = noise_item();
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.op          = OP_LOAD;
      it.plane_index = ($urandom_range(19) == 0) ? IDX_W'($urandom_range(7, 6))
                                                 : IDX_W'($urandom_range(5));
      pick = $urandom_range(99);
      if (pick < 25) begin
        // full-range normal and offset from the noise fill
      end else if (pick < 60) begin
        unit = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        it.normal_x = '0;
        it.normal_y = '0;
        it.normal_z = '0;
        pick = $urandom_range(2);
        if (pick == 0) it.normal_x = unit;
        else if (pick == 1) it.normal_y = unit;
        else it.normal_z = unit;
        it.plane_offset = near_value(18);
      end else if (pick < 85) begin
        it.normal_x     = NORMAL_W'($urandom_range(32768)) - 16'sd16384;
        it.normal_y     = NORMAL_W'($urandom_range(32768)) - 16'sd16384;
        it.normal_z     = NORMAL_W'($urandom_range(32768)) - 16'sd16384;
        it.plane_offset = near_value(18);
      end else begin
        // disabled plane
        it.normal_x     = '0;
        it.normal_y     = '0;
        it.normal_z     = '0;
        it.plane_offset = '0;
      end
    end else begin
      it.op = OP_TEST;
      if ($urandom_range(99) < 70) begin
        it.center_x = near_value(18);
        it.center_y = near_value(18);
        it.center_z = near_value(18);
        it.extent_x = near_value(17);
        it.extent_y = near_value(17);
        it.extent_z = near_value(17);
      end
    end
    return it;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(cull_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= it.op;
    in_plane_index  <= it.plane_index;
    in_normal_x     <= it.normal_x;
    in_normal_y     <= it.normal_y;
    in_normal_z     <= it.normal_z;
    in_plane_offset <= it.plane_offset;
    in_center_x     <= it.center_x;
    in_center_y     <= it.center_y;
    in_center_z     <= it.center_z;
    in_extent_x     <= it.extent_x;
    in_extent_y     <= it.extent_y;
    in_extent_z     <= it.extent_z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  // wait for all verdicts, then let trailing loads clear the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_tolerance(value);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // no planes loaded yet, everything passes
    send_item(test_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    send_item(test_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // single +x plane, tolerance boundary at the reset value
    send_item(load_item(0, 16384, 0, 0, 0));
    send_item(test_item(1, 0, 0, 0, 0, 0));
    send_item(test_item(2, 0, 0, 0, 0, 0));
    send_item(test_item(2, 0, 0, 1, 0, 0));
    send_item(test_item(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
    // out of range plane indexes are dropped
    send_item(load_item(6, -32768, -32768, -32768, 32'h7FFF_FFFF));
    send_item(load_item(7, -32768, 32767, 1, 32'h8000_0000));
    send_item(test_item(2, 0, 0, 0, 0, 0));
    // extreme normals and offsets
    send_item(load_item(1, -32768, -32768, -32768, 32'h7FFF_FFFF));
    send_item(test_item(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(test_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    send_item(load_item(2, 16384, 16384, 16384, 32'h8000_0000));
    send_item(load_item(3, -16384, 16384, -16384, 0));
    send_item(load_item(4, 0, -16384, 0, -1));
    send_item(load_item(5, 32767, -1, 1, 1));
    send_item(test_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(test_item(0, 0, 0, 0, 0, 0));
    // back to a single plane before the random part
    for (int i = 1; i < PLANE_CNT; i++) send_item(load_item(i, 0, 0, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1, 5:    write_tolerance('0);
          2:       write_tolerance('1);
          default: write_tolerance(TOL_W'($urandom));
        endcase
      end
      case (p % 4)
        1:       begin idle_pct = 49; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 49; end
        3:       begin idle_pct = 30; stall_pct = 30; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      repeat (PHASE_ITEMS) send_item(random_item());
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_aabb_frustum_cull: done, clean");
    end else begin
      $display("tb_aabb_frustum_cull: done, errors");
    end
    $finish;
  end

endmodule
